### rtl/ubxr_pkg.sv
// shared types and constants for the ubx frame receiver
// no dependencies; imported by every module of the block
package ubxr_pkg;

	localparam int unsigned CAPTURE_BYTES = 68;
	localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_BYTES);
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  SYNC1_BYTE    = 8'hB5;
	localparam logic [7:0]  SYNC2_BYTE    = 8'h62;
	localparam logic [7:0]  CLS_NAV       = 8'h01;
	localparam logic [7:0]  ID_NAV_PVT    = 8'h07;
	localparam logic [7:0]  CLS_ACK       = 8'h05;
	localparam logic [7:0]  ID_ACK_ACK    = 8'h01;
	localparam logic [7:0]  ID_ACK_NAK    = 8'h00;
	localparam logic [15:0] MAX_LEN_RESET = 16'd92;

	// payload offsets of the captured fields
	localparam int unsigned OFF_FIX  = 20;
	localparam int unsigned OFF_NSAT = 23;
	localparam int unsigned OFF_LON  = 24;
	localparam int unsigned OFF_LAT  = 28;
	localparam int unsigned OFF_HGT  = 32;
	localparam int unsigned OFF_VELN = 48;
	localparam int unsigned OFF_VELE = 52;
	localparam int unsigned OFF_VELD = 56;
	localparam int unsigned OFF_GSPD = 60;
	localparam int unsigned OFF_HEAD = 64;

	typedef enum logic [3:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_CLASS,
		PH_IDENT,
		PH_LENLO,
		PH_LENHI,
		PH_BODY,
		PH_CKA,
		PH_CKB
	} phase_t;

	typedef enum logic [2:0] {
		ST_NAV_PVT,
		ST_ACK,
		ST_NAK,
		ST_UNKNOWN,
		ST_CKSUM_ERR,
		ST_LEN_ERR
	} status_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_WRITE,
		OP_EMIT
	} op_kind_t;

	// one queued command from the parser to the capture / report side
	typedef struct packed {
		op_kind_t               kind;
		logic [CAP_IDX_W-1:0]   idx;
		logic [7:0]             data;
		status_t                status;
		logic [15:0]            class_id;
	} op_t;

endpackage

### rtl/ubxr_front.sv
// byte parser: preamble hunt, header, length check and fletcher-8 sum
// depends on ubxr_pkg; emits one op per byte that needs back-end action
module ubxr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    rx_byte,
	output logic          push_valid,
	output ubxr_pkg::op_t push_op,
	input  logic          queue_full
);
	import ubxr_pkg::*;

	phase_t      phase_q, phase_nxt;
	logic [15:0] max_len_q;
	logic [7:0]  class_q;
	logic [7:0]  ident_q;
	logic [15:0] plen_q;
	logic [15:0] bidx_q;
	logic [7:0]  sum_a_q;
	logic [7:0]  sum_b_q;
	logic [7:0]  cka_q;

	logic        accept;
	logic        need_op;
	logic [15:0] len_full;
	logic        len_err;
	logic [15:0] bidx_inc;
	logic [7:0]  acc_a;
	logic [7:0]  acc_b;
	status_t     end_status;

	assign in_stall   = queue_full;
	assign accept     = in_valid & ~queue_full;
	assign push_valid = accept & need_op;

	assign len_full = {rx_byte, plen_q[7:0]};
	assign len_err  = len_full > max_len_q;
	assign bidx_inc = bidx_q + 16'd1;
	assign acc_a    = sum_a_q + rx_byte;
	assign acc_b    = sum_b_q + acc_a;

	always_comb begin
		priority if (cka_q != sum_a_q || rx_byte != sum_b_q)
			end_status = ST_CKSUM_ERR;
		else if (class_q == CLS_NAV && ident_q == ID_NAV_PVT)
			end_status = ST_NAV_PVT;
		else if (class_q == CLS_ACK && ident_q == ID_ACK_ACK)
			end_status = ST_ACK;
		else if (class_q == CLS_ACK && ident_q == ID_ACK_NAK)
			end_status = ST_NAK;
		else
			end_status = ST_UNKNOWN;
	end

	// next phase
	always_comb begin
		unique case (phase_q)
			PH_SYNC1: phase_nxt = (rx_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2: phase_nxt = (rx_byte == SYNC2_BYTE) ? PH_CLASS : PH_SYNC1;
			PH_CLASS: phase_nxt = PH_IDENT;
			PH_IDENT: phase_nxt = PH_LENLO;
			PH_LENLO: phase_nxt = PH_LENHI;
			PH_LENHI: begin
				if (len_err)
					phase_nxt = PH_SYNC1;
				else if (len_full == 16'd0)
					phase_nxt = PH_CKA;
				else
					phase_nxt = PH_BODY;
			end
			PH_BODY:  phase_nxt = (bidx_inc >= plen_q) ? PH_CKA : PH_BODY;
			PH_CKA:   phase_nxt = PH_CKB;
			PH_CKB:   phase_nxt = PH_SYNC1;
			default:  phase_nxt = PH_SYNC1;
		endcase
	end

	// op generation
	always_comb begin
		need_op          = 1'b0;
		push_op.kind     = OP_WRITE;
		push_op.idx      = bidx_q[CAP_IDX_W-1:0];
		push_op.data     = rx_byte;
		push_op.status   = end_status;
		push_op.class_id = {class_q, ident_q};
		unique case (phase_q)
			PH_LENHI: begin
				need_op        = 1'b1;
				push_op.kind   = len_err ? OP_EMIT : OP_CLEAR;
				push_op.status = ST_LEN_ERR;
			end
			PH_BODY: begin
				need_op = bidx_q < 16'(CAPTURE_BYTES);
			end
			PH_CKB: begin
				need_op      = 1'b1;
				push_op.kind = OP_EMIT;
			end
			default: begin
				need_op = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC1;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (cfg_wr_en)
				max_len_q <= cfg_wr_data;
			if (accept)
				phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (phase_q)
				PH_CLASS: begin
					class_q <= rx_byte;
					sum_a_q <= rx_byte;
					sum_b_q <= rx_byte;
				end
				PH_IDENT: begin
					ident_q <= rx_byte;
					sum_a_q <= acc_a;
					sum_b_q <= acc_b;
				end
				PH_LENLO: begin
					plen_q  <= {8'h00, rx_byte};
					sum_a_q <= acc_a;
					sum_b_q <= acc_b;
				end
				PH_LENHI: begin
					plen_q  <= len_full;
					bidx_q  <= 16'd0;
					sum_a_q <= acc_a;
					sum_b_q <= acc_b;
				end
				PH_BODY: begin
					bidx_q  <= bidx_inc;
					sum_a_q <= acc_a;
					sum_b_q <= acc_b;
				end
				PH_CKA: begin
					cka_q <= rx_byte;
				end
				default: begin
					cka_q <= cka_q;
				end
			endcase
		end
	end

endmodule

### rtl/ubxr_queue.sv
// small fifo of parser ops between the front and back ends
// depends on ubxr_pkg
module ubxr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ubxr_pkg::op_t push_op,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ubxr_pkg::op_t pop_op
);
	import ubxr_pkg::*;

	op_t                    mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_pop;

	assign full      = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op    = mem_q[rd_ptr_q];
	assign do_pop    = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push_valid)
			mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			if (push_valid && !do_pop)
				count_q <= count_q + QUEUE_CNT_W'(1);
			else if (!push_valid && do_pop)
				count_q <= count_q - QUEUE_CNT_W'(1);
		end
	end

endmodule

### rtl/ubxr_back.sv
// payload capture bytes and the registered report output
// depends on ubxr_pkg; consumes ops from ubxr_queue
module ubxr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ubxr_pkg::op_t       pop_op,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          frame_status,
	output logic [15:0]         class_and_id,
	output logic signed [31:0]  latitude_raw,
	output logic signed [31:0]  longitude_raw,
	output logic signed [31:0]  height_raw,
	output logic signed [31:0]  vel_north_raw,
	output logic signed [31:0]  vel_east_raw,
	output logic signed [31:0]  vel_down_raw,
	output logic signed [31:0]  ground_speed_raw,
	output logic signed [31:0]  heading_raw,
	output logic [7:0]          satellite_count,
	output logic                fix_valid
);
	import ubxr_pkg::*;

	logic [7:0] cap_q [CAPTURE_BYTES];
	logic       out_valid_q;
	logic       out_free;
	logic       take;
	logic       emit;
	logic       is_pvt;

	function automatic logic [31:0] word_at(input logic [CAP_IDX_W-1:0] off);
		return {cap_q[off + CAP_IDX_W'(3)], cap_q[off + CAP_IDX_W'(2)],
			cap_q[off + CAP_IDX_W'(1)], cap_q[off]};
	endfunction

	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign pop_ready = (pop_op.kind != OP_EMIT) | out_free;
	assign take      = pop_valid & pop_ready;
	assign emit      = take & (pop_op.kind == OP_EMIT);
	assign is_pvt    = pop_op.status == ST_NAV_PVT;

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (pop_op.kind)
				OP_CLEAR: begin
					for (int i = 0; i < CAPTURE_BYTES; i++)
						cap_q[CAP_IDX_W'(i)] <= 8'h00;
				end
				OP_WRITE: begin
					cap_q[pop_op.idx] <= pop_op.data;
				end
				default: begin
					cap_q[0] <= cap_q[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_status     <= pop_op.status;
			class_and_id     <= pop_op.class_id;
			latitude_raw     <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_LAT)))  : 32'sd0;
			longitude_raw    <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_LON)))  : 32'sd0;
			height_raw       <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_HGT)))  : 32'sd0;
			vel_north_raw    <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_VELN))) : 32'sd0;
			vel_east_raw     <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_VELE))) : 32'sd0;
			vel_down_raw     <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_VELD))) : 32'sd0;
			ground_speed_raw <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_GSPD))) : 32'sd0;
			heading_raw      <= is_pvt ? $signed(word_at(CAP_IDX_W'(OFF_HEAD))) : 32'sd0;
			satellite_count  <= is_pvt ? cap_q[CAP_IDX_W'(OFF_NSAT)] : 8'h00;
			fix_valid        <= is_pvt & (cap_q[CAP_IDX_W'(OFF_FIX)] != 8'h00);
		end
	end

endmodule

### rtl/ubx_frame_receiver_pvt_extract.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// config    | cfg_wr_en            | cfg_wr_data (max payload length)
// input     | in_valid / in_stall  | rx_byte
// output    | out_valid / out_stall| frame_status, class_and_id, pvt fields
//
// a byte is taken every cycle while in_stall is low; the parser never waits
// on the byte itself. after the frame's last byte a report passes the op
// queue and output register; the four-entry op queue sets how far a held
// output lags. in_stall rises only when the op queue is full, i.e. after
// out_stall has held a report long enough for four pending ops to pile up.
// reset clears the parser phase, the queue and out_valid; max length returns to 92.
// top level: ubxr_front -> ubxr_queue -> ubxr_back, all using ubxr_pkg
module ubx_frame_receiver_pvt_extract (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         frame_status,
	output logic [15:0]        class_and_id,
	output logic signed [31:0] latitude_raw,
	output logic signed [31:0] longitude_raw,
	output logic signed [31:0] height_raw,
	output logic signed [31:0] vel_north_raw,
	output logic signed [31:0] vel_east_raw,
	output logic signed [31:0] vel_down_raw,
	output logic signed [31:0] ground_speed_raw,
	output logic signed [31:0] heading_raw,
	output logic [7:0]         satellite_count,
	output logic               fix_valid
);
	import ubxr_pkg::*;

	logic push_valid;
	op_t  push_op;
	logic queue_full;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	ubxr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.push_valid  (push_valid),
		.push_op     (push_op),
		.queue_full  (queue_full)
	);

	ubxr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	ubxr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop_ready        (pop_ready),
		.pop_op           (pop_op),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_status     (frame_status),
		.class_and_id     (class_and_id),
		.latitude_raw     (latitude_raw),
		.longitude_raw    (longitude_raw),
		.height_raw       (height_raw),
		.vel_north_raw    (vel_north_raw),
		.vel_east_raw     (vel_east_raw),
		.vel_down_raw     (vel_down_raw),
		.ground_speed_raw (ground_speed_raw),
		.heading_raw      (heading_raw),
		.satellite_count  (satellite_count),
		.fix_valid        (fix_valid)
	);

endmodule

### rtl/ubxr_checker.sv
// port-level checks for the ubx frame receiver, bound to the top level
// depends on ubxr_pkg
module ubxr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         frame_status,
	input logic [15:0]        class_and_id,
	input logic signed [31:0] latitude_raw,
	input logic signed [31:0] longitude_raw,
	input logic signed [31:0] heading_raw,
	input logic [7:0]         satellite_count,
	input logic               fix_valid
);
	import ubxr_pkg::*;

	// held report must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_status)
			&& $stable(class_and_id) && $stable(latitude_raw))
		else $error("output transaction changed while stalled");

	// only nav-pvt reports carry position data
	a_non_pvt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != ST_NAV_PVT |-> latitude_raw == 32'sd0
			&& longitude_raw == 32'sd0 && heading_raw == 32'sd0
			&& satellite_count == 8'h00 && !fix_valid)
		else $error("non-pvt report has nonzero pvt fields");

	a_pvt_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == ST_NAV_PVT |-> class_and_id == {CLS_NAV, ID_NAV_PVT})
		else $error("pvt report with wrong class/id");

	a_ack_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_status == ST_ACK || frame_status == ST_NAK)
			|-> class_and_id[15:8] == CLS_ACK
			&& (class_and_id[7:0] == ID_ACK_ACK) == (frame_status == ST_ACK))
		else $error("ack/nak report with wrong class/id");

endmodule

bind ubx_frame_receiver_pvt_extract ubxr_checker u_ubxr_checker (.*);
